### rtl/core/tlx_pkg.sv
// Shared types, constants and character-class functions of the token lexer.
package tlx_pkg;

  localparam int MAX_LEN = 255;
  localparam int LEN_CAP_I = (MAX_LEN < 255) ? MAX_LEN : 255;
  localparam logic [7:0] LEN_CAP = 8'(LEN_CAP_I);

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_LF    = 8'h0a;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_UNDER = 8'h5f;

  localparam logic [7:0] LEN_INT = 8'd3;
  localparam logic [7:0] LEN_RET = 8'd6;

  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_END  = 1'b1;

  typedef enum logic [2:0] {
    K_ID   = 3'd0,
    K_NUM  = 3'd1,
    K_INT  = 3'd2,
    K_RET  = 3'd3,
    K_MARK = 3'd4,
    K_END  = 3'd5
  } kind_t;

  typedef enum logic [1:0] {
    M_IDLE  = 2'd0,
    M_IDENT = 2'd1,
    M_NUM   = 2'd2
  } mode_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] length;
    logic [7:0] mark_char;
    logic       last;
  } tok_t;

  function automatic logic is_letter(input logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7a) || (c >= 8'h41 && c <= 8'h5a);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  function automatic logic is_begin(input logic [7:0] c);
    return is_letter(c) || c == CH_UNDER;
  endfunction

  function automatic logic is_part(input logic [7:0] c);
    return is_begin(c) || is_digit(c);
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return c == CH_SPACE || c == CH_LF || c == CH_TAB;
  endfunction

  // letter of "int" at a given position
  function automatic logic [7:0] int_char(input logic [1:0] idx);
    logic [7:0] c;
    case (idx)
      2'd0:    c = 8'h69;
      2'd1:    c = 8'h6e;
      default: c = 8'h74;
    endcase
    return c;
  endfunction

  // letter of "return" at a given position
  function automatic logic [7:0] ret_char(input logic [2:0] idx);
    logic [7:0] c;
    case (idx)
      3'd0:    c = 8'h72;
      3'd1:    c = 8'h65;
      3'd2:    c = 8'h74;
      3'd3:    c = 8'h75;
      3'd4:    c = 8'h72;
      default: c = 8'h6e;
    endcase
    return c;
  endfunction

endpackage

### rtl/core/tlx_in_if.sv
// Input channel of the token lexer: one source byte or end marker per beat.
interface tlx_in_if;
  logic       valid;
  logic       ready;
  logic       op;
  logic [7:0] ch;

  modport source (output valid, output op, output ch, input ready);
  modport sink   (input valid, input op, input ch, output ready);
endinterface

### rtl/core/tlx_out_if.sv
// Result channel of the token lexer: one token per beat.
interface tlx_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] kind;
  logic [7:0] length;
  logic [7:0] mark_char;
  logic       last;

  modport source (output valid, output kind, output length, output mark_char,
                  output last, input ready);
  modport sink   (input valid, input kind, input length, input mark_char,
                  input last, output ready);
endinterface

### rtl/core/token_lexer.sv
// Token lexer top level: byte stream in, tokens out.
// A token is registered: the first one a beat ends appears on the output in the cycle after that beat.
// Throughput: one input beat per cycle while the output is not stalled; a beat
// that ends a token and also gives a mark or end token yields two result beats,
// and the input stalls until the single result port has drained the second one.
// Reset (rst_n low, synchronous): lexer idle, no token pending, output empty.
module token_lexer (
  input  logic clk,
  input  logic rst_n,
  tlx_in_if.sink    in_ch,
  tlx_out_if.source out_ch
);
  import tlx_pkg::*;

  // lexer state
  mode_t      mode_r, mode_nxt;
  logic [7:0] run_r, run_nxt;
  logic       int_r, int_nxt;
  logic       ret_r, ret_nxt;

  // result register and the held second result
  tok_t out_r, out_nxt;
  logic out_valid_r, out_valid_nxt;
  tok_t hold_r, hold_nxt;
  logic hold_valid_r, hold_valid_nxt;

  logic accept;
  logic take;

  // per-beat results
  tok_t       res0, res1;
  logic [1:0] n_res;

  tok_t       pend_tok;
  tok_t       end_tok;
  tok_t       mark_tok;
  logic       at_break;
  logic       has_pend;
  logic [7:0] run_inc;

  // Take a beat only while no second result is held back and the output
  // register is empty or being emptied this cycle.
  assign take   = out_valid_r && out_ch.ready;
  assign accept = in_ch.valid && in_ch.ready;
  assign in_ch.ready = !hold_valid_r && (!out_valid_r || out_ch.ready);

  assign has_pend = (mode_r != M_IDLE);
  // end of input counts as a break, as does whitespace
  assign at_break = (in_ch.op == OP_END) || is_space(in_ch.ch);
  assign run_inc  = (run_r < LEN_CAP) ? run_r + 8'd1 : run_r;

  // pending token as it would be flushed now
  always_comb begin
    pend_tok           = '0;
    pend_tok.length    = run_r;
    pend_tok.mark_char = 8'h00;
    if (mode_r == M_NUM) begin
      pend_tok.kind = K_NUM;
    end else if (at_break && int_r && run_r == LEN_INT) begin
      pend_tok.kind = K_INT;
    end else if (at_break && ret_r && run_r == LEN_RET) begin
      pend_tok.kind = K_RET;
    end else begin
      pend_tok.kind = K_ID;
    end

    end_tok      = '0;
    end_tok.kind = K_END;

    mark_tok           = '0;
    mark_tok.kind      = K_MARK;
    mark_tok.length    = 8'd1;
    mark_tok.mark_char = in_ch.ch;
  end

  // next lexer state and the results of the current beat
  always_comb begin
    mode_nxt = mode_r;
    run_nxt  = run_r;
    int_nxt  = int_r;
    ret_nxt  = ret_r;
    res0     = '0;
    res1     = '0;
    n_res    = 2'd0;

    if (in_ch.op == OP_END) begin
      mode_nxt = M_IDLE;
      run_nxt  = 8'd0;
      int_nxt  = 1'b0;
      ret_nxt  = 1'b0;
      if (has_pend) begin
        res0  = pend_tok;
        res1  = end_tok;
        n_res = 2'd2;
      end else begin
        res0  = end_tok;
        n_res = 2'd1;
      end
    end else if (mode_r == M_IDENT && is_part(in_ch.ch)) begin
      // keyword tracking: still a prefix of the word at this position
      int_nxt = int_r && (run_r < LEN_INT) && (in_ch.ch == int_char(run_r[1:0]));
      ret_nxt = ret_r && (run_r < LEN_RET) && (in_ch.ch == ret_char(run_r[2:0]));
      run_nxt = run_inc;
    end else if (mode_r == M_NUM && is_digit(in_ch.ch)) begin
      run_nxt = run_inc;
    end else begin
      // the pending token (if any) ends here; this byte may open a new one
      if (has_pend) begin
        res0  = pend_tok;
        n_res = 2'd1;
      end
      mode_nxt = M_IDLE;
      run_nxt  = 8'd0;
      int_nxt  = 1'b0;
      ret_nxt  = 1'b0;
      if (is_space(in_ch.ch)) begin
        // skipped
      end else if (is_begin(in_ch.ch)) begin
        mode_nxt = M_IDENT;
        run_nxt  = 8'd1;
        int_nxt  = (in_ch.ch == int_char(2'd0));
        ret_nxt  = (in_ch.ch == ret_char(3'd0));
      end else if (is_digit(in_ch.ch)) begin
        mode_nxt = M_NUM;
        run_nxt  = 8'd1;
      end else if (has_pend) begin
        res1  = mark_tok;
        n_res = 2'd2;
      end else begin
        res0  = mark_tok;
        n_res = 2'd1;
      end
    end

    // flag the final result of this beat
    if (n_res == 2'd2) begin
      res1.last = 1'b1;
    end else if (n_res == 2'd1) begin
      res0.last = 1'b1;
    end
  end

  // output register and hold register
  always_comb begin
    out_nxt        = out_r;
    out_valid_nxt  = out_valid_r;
    hold_nxt       = hold_r;
    hold_valid_nxt = hold_valid_r;

    if (take) begin
      if (hold_valid_r) begin
        out_nxt        = hold_r;
        hold_valid_nxt = 1'b0;
      end else begin
        out_valid_nxt = 1'b0;
      end
    end

    // accept implies the hold register is empty and the output is free
    if (accept && n_res != 2'd0) begin
      out_nxt       = res0;
      out_valid_nxt = 1'b1;
      if (n_res == 2'd2) begin
        hold_nxt       = res1;
        hold_valid_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r       <= M_IDLE;
      run_r        <= 8'd0;
      int_r        <= 1'b0;
      ret_r        <= 1'b0;
      out_valid_r  <= 1'b0;
      hold_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        mode_r <= mode_nxt;
        run_r  <= run_nxt;
        int_r  <= int_nxt;
        ret_r  <= ret_nxt;
      end
      out_valid_r  <= out_valid_nxt;
      hold_valid_r <= hold_valid_nxt;
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    out_r  <= out_nxt;
    hold_r <= hold_nxt;
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.kind      = out_r.kind;
  assign out_ch.length    = out_r.length;
  assign out_ch.mark_char = out_r.mark_char;
  assign out_ch.last      = out_r.last;

endmodule

### tb/sv/token_lexer_test.sv
// Self-checking testbench for token_lexer: byte-stream stimulus, token scoreboard.
module token_lexer_test;
  import tlx_pkg::*;

  localparam int HALF_PERIOD = 10;
  // Generous cap: roughly 1750 beats, each worst case a random gap plus two
  // tokens that each sit out a random receiver stall; allow far more.
  localparam int RUN_LIMIT   = 20_000_000;
  // Cycles allowed for the last tokens to drain once the stimulus has stopped.
  localparam int DRAIN_LIMIT = 2000;

  logic clk;
  logic rst_n;

  tlx_in_if  in_ch ();
  tlx_out_if out_ch ();

  token_lexer uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #HALF_PERIOD clk = ~clk;

  // ---------------------------------------------------------------------------
  // Lexer shadow state and the tokens still owed by the block
  // ---------------------------------------------------------------------------
  mode_t      lx_mode;
  logic [7:0] lx_len;
  logic       lx_int_ok;    // pending word is still a prefix of "int"
  logic       lx_ret_ok;    // pending word is still a prefix of "return"
  string      int_word = "int";
  string      ret_word = "return";

  tok_t tokens_due[$];      // expected tokens, oldest first
  tok_t step_toks[$];       // tokens caused by the beat being predicted

  int  beats_sent;
  int  fails;
  bit  tx_calm;             // sender runs back to back while set
  bit  rx_calm;             // receiver never stalls while set
  int  rx_hold;             // cycles the receiver still holds ready low

  // Word list for the text stream: keywords, near misses and keyword prefixes.
  string vocab[$] = '{"int", "return", "in", "inta", "int_", "retur", "returns",
                      "return7", "i", "r", "_", "x9", "nt", "eturn", "INT"};

  // ---------------------------------------------------------------------------
  // Character classes
  // ---------------------------------------------------------------------------
  function automatic logic blank_c(logic [7:0] c);
    return c == CH_SPACE || c == CH_LF || c == CH_TAB;
  endfunction

  function automatic logic digit_c(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic word_start_c(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == CH_UNDER;
  endfunction

  function automatic logic word_part_c(logic [7:0] c);
    return word_start_c(c) || digit_c(c);
  endfunction

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------
  function automatic void add_tok(kind_t k, logic [7:0] len, logic [7:0] mc);
    tok_t t;
    t.kind      = k;
    t.length    = len;
    t.mark_char = mc;
    t.last      = 1'b0;
    step_toks.push_back(t);
  endfunction

  // Emit whatever run is pending. Keywords only count when a blank or the end
  // of input closes them; a mark closing "int" leaves a plain identifier.
  function automatic void close_run(logic at_break);
    kind_t k;
    k = K_ID;
    if (lx_mode == M_IDLE) return;
    if (lx_mode == M_NUM) k = K_NUM;
    else if (at_break && lx_int_ok && lx_len == LEN_INT) k = K_INT;
    else if (at_break && lx_ret_ok && lx_len == LEN_RET) k = K_RET;
    add_tok(k, lx_len, 8'h00);
    lx_mode   = M_IDLE;
    lx_len    = 8'd0;
    lx_int_ok = 1'b0;
    lx_ret_ok = 1'b0;
  endfunction

  // Work out the tokens one accepted beat causes and queue them.
  function automatic void lex_step(logic op, logic [7:0] c);
    step_toks.delete();
    if (op == OP_END) begin
      close_run(1'b1);
      add_tok(K_END, 8'd0, 8'h00);
    end else if (lx_mode == M_IDENT && word_part_c(c)) begin
      lx_int_ok = lx_int_ok && lx_len < LEN_INT && c == 8'(int_word[lx_len]);
      lx_ret_ok = lx_ret_ok && lx_len < LEN_RET && c == 8'(ret_word[lx_len]);
      if (lx_len < LEN_CAP) lx_len = lx_len + 8'd1;
    end else if (lx_mode == M_NUM && digit_c(c)) begin
      if (lx_len < LEN_CAP) lx_len = lx_len + 8'd1;
    end else begin
      // anything else ends the pending run; a letter after a number lands
      // here too and opens a fresh run
      close_run(blank_c(c));
      if (word_start_c(c)) begin
        lx_mode   = M_IDENT;
        lx_len    = 8'd1;
        lx_int_ok = (c == "i");
        lx_ret_ok = (c == "r");
      end else if (digit_c(c)) begin
        lx_mode = M_NUM;
        lx_len  = 8'd1;
      end else if (!blank_c(c)) begin
        add_tok(K_MARK, 8'd1, c);
      end
    end
    if (step_toks.size() > 0) step_toks[step_toks.size() - 1].last = 1'b1;
    foreach (step_toks[i]) tokens_due.push_back(step_toks[i]);
  endfunction

  // ---------------------------------------------------------------------------
  // Input side: one beat per call, inputs change on the falling edge
  // ---------------------------------------------------------------------------
  task automatic send_beat(logic op, logic [7:0] c);
    int gap;
    // flip between busy and calm stretches now and then
    if ($urandom_range(0, 39) == 0) tx_calm = !tx_calm;
    if ($urandom_range(0, 39) == 0) rx_calm = !rx_calm;
    gap = tx_calm ? 0 : $urandom_range(0, 12);
    @(negedge clk);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.op    <= op;
    in_ch.ch    <= c;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    lex_step(op, c);
    beats_sent++;
  endtask

  task automatic send_word(string w);
    for (int i = 0; i < w.len(); i++) send_beat(OP_BYTE, 8'(w[i]));
  endtask

  function automatic logic [7:0] pick_digit();
    return 8'("0" + $urandom_range(0, 9));
  endfunction

  // Letter, underscore or (unless first) digit.
  function automatic logic [7:0] pick_word_char(logic first);
    int r;
    r = $urandom_range(0, first ? 52 : 62);
    if (r < 26) return 8'("a" + r);
    if (r < 52) return 8'("A" + r - 26);
    if (r == 52) return CH_UNDER;
    return 8'("0" + r - 53);
  endfunction

  function automatic logic [7:0] pick_blank();
    case ($urandom_range(0, 2))
      0:       return CH_SPACE;
      1:       return CH_LF;
      default: return CH_TAB;
    endcase
  endfunction

  // Any byte that is neither part of a word nor blank: CR, NUL, high bytes...
  function automatic logic [7:0] pick_mark();
    logic [7:0] r;
    do r = 8'($urandom_range(0, 255)); while (word_part_c(r) || blank_c(r));
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Output side: ready changes on the falling edge, checks on the rising edge
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (rx_hold > 0) begin
      out_ch.ready <= 1'b0;
      rx_hold      <= rx_hold - 1;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin : check_beat
    tok_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      // stall drawn afresh for the next token
      rx_hold <= rx_calm ? 0 : $urandom_range(0, 12);
      if (tokens_due.size() == 0) begin
        $error("unexpected token: kind %0d length %0d mark_char %0h",
               out_ch.kind, out_ch.length, out_ch.mark_char);
        fails++;
      end else begin
        want = tokens_due.pop_front();
        if (out_ch.kind !== want.kind) begin
          $error("kind: expected %0d, got %0d", want.kind, out_ch.kind);
          fails++;
        end
        if (out_ch.length !== want.length) begin
          $error("length: expected %0d, got %0d", want.length, out_ch.length);
          fails++;
        end
        if (out_ch.mark_char !== want.mark_char) begin
          $error("mark_char: expected %0h, got %0h", want.mark_char, out_ch.mark_char);
          fails++;
        end
        if (out_ch.last !== want.last) begin
          $error("last: expected %0b, got %0b", want.last, out_ch.last);
          fails++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Keywords closed by end, blank and mark; blank and end while idle;
  // number running into a letter; marks at NUL, 0xff and carriage return.
  task automatic test_directed();
    send_word("int");
    send_beat(OP_END, 8'hff);          // keyword int, then end; ch ignored
    send_beat(OP_BYTE, CH_SPACE);      // blank while idle: nothing
    send_word("return");
    send_beat(OP_BYTE, CH_TAB);        // keyword return
    send_word("int");
    send_beat(OP_BYTE, 8'h00);         // plain identifier, then NUL mark
    send_word("_Z9");
    send_beat(OP_BYTE, CH_LF);
    send_word("9a");                   // number ends, identifier begins
    send_beat(OP_BYTE, 8'hff);
    send_beat(OP_BYTE, 8'h0d);         // CR is a mark, not a blank
    send_beat(OP_END, 8'h00);          // end while idle: end token only
  endtask

  // Mostly well-formed text with random words, numbers and separators.
  task automatic test_word_stream();
    int len;
    while (beats_sent < 800) begin
      case ($urandom_range(0, 7))
        0, 1, 2: send_word(vocab[$urandom_range(0, vocab.size() - 1)]);
        3, 4: begin
          len = $urandom_range(1, 8);
          send_beat(OP_BYTE, pick_word_char(1'b1));
          repeat (len - 1) send_beat(OP_BYTE, pick_word_char(1'b0));
        end
        5, 6: repeat ($urandom_range(1, 6)) send_beat(OP_BYTE, pick_digit());
        default: send_beat(OP_BYTE, 8'($urandom_range(0, 255)));  // stray byte
      endcase
      case ($urandom_range(0, 5))
        0, 1, 2: send_beat(OP_BYTE, pick_blank());
        3:       ;                                // tokens run together
        4:       send_beat(OP_BYTE, pick_mark());
        default: send_beat(OP_END, 8'($urandom_range(0, 255)));
      endcase
    end
  endtask

  // Runs past the length cap, for words and numbers; one starts as "return".
  task automatic test_long_runs();
    send_word("return");
    repeat (250) send_beat(OP_BYTE, pick_word_char(1'b0));
    send_beat(OP_BYTE, pick_blank());
    repeat (260) send_beat(OP_BYTE, pick_digit());
    send_beat(OP_END, 8'h00);
    send_beat(OP_BYTE, pick_word_char(1'b1));
    repeat (255) send_beat(OP_BYTE, pick_word_char(1'b0));
    send_beat(OP_BYTE, pick_mark());
  endtask

  // Unshaped bytes with the odd end marker; closes with a flush.
  task automatic test_raw_bytes();
    repeat (150)
      send_beat(($urandom_range(0, 15) == 0) ? OP_END : OP_BYTE,
                8'($urandom_range(0, 255)));
    send_beat(OP_END, 8'($urandom_range(0, 255)));
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    int n;
    clk          = 1'b0;
    rst_n        = 1'b0;
    in_ch.valid  = 1'b0;
    in_ch.op     = OP_BYTE;
    in_ch.ch     = 8'h00;
    out_ch.ready = 1'b0;
    rx_hold      = 0;
    tx_calm      = 1'b0;
    rx_calm      = 1'b0;
    beats_sent   = 0;
    fails        = 0;
    lx_mode      = M_IDLE;
    lx_len       = 8'd0;
    lx_int_ok    = 1'b0;
    lx_ret_ok    = 1'b0;

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_directed();
    test_word_stream();
    test_long_runs();
    test_raw_bytes();

    @(negedge clk);
    in_ch.valid <= 1'b0;

    // drain: wait for every owed token, then keep watching for strays
    for (n = 0; n < DRAIN_LIMIT && tokens_due.size() != 0; n++) @(posedge clk);
    repeat (4) @(posedge clk);
    if (tokens_due.size() != 0) begin
      $error("tokens never delivered: %0d", tokens_due.size());
      fails++;
    end

    if (fails == 0) begin
      $display("token_lexer_test: done, clean");
    end else begin
      $display("token_lexer_test: done, errors");
    end
    $finish;
  end

  initial begin
    #(RUN_LIMIT);
    $display("token_lexer_test: done, errors");
    $finish;
  end

endmodule
